// File: rtl/xoshiro_random_request_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the xoshiro random request unit
// Shared forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef XOSHIRO_RANDOM_REQUEST_UNIT_MACROS_SVH
`define XOSHIRO_RANDOM_REQUEST_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define XRRU_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define XRRU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/xrru_pkg.sv
// ---------------------------------------------------------------------------
// xrru_pkg
// Types and constants shared by the random request unit modules.
// ---------------------------------------------------------------------------
package xrru_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic REG_SEED = 1'b0;

  localparam logic [63:0] SEED_RESET   = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

  localparam logic [1:0] REQ_RAW    = 2'd0;
  localparam logic [1:0] REQ_RANGE  = 2'd1;
  localparam logic [1:0] REQ_INDEX  = 2'd2;
  localparam logic [1:0] REQ_CHANCE = 2'd3;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_SEED_INIT,
    ST_SEED_ADD,
    ST_MULA_LO,
    ST_MULA_HI,
    ST_MULA_X,
    ST_MIX,
    ST_MULB_LO,
    ST_MULB_HI,
    ST_MULB_X,
    ST_STORE,
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic       seed_init;
    logic       seed_add;
    logic       mul_lo;
    logic       mul_cross_hi;
    logic       mul_cross_lo;
    logic       mul_const_b;
    logic       mix;
    logic       store;
    logic [1:0] word_idx;
    logic       accept;
    logic       div_step;
    logic       finish;
  } xrru_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } xrru_status_t;

endpackage

// File: rtl/xrru_ctrl.sv
// ---------------------------------------------------------------------------
// xrru_ctrl
// Sequencer for seed expansion, request acceptance, division and result load.
// ---------------------------------------------------------------------------
module xrru_ctrl
  import xrru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         seed_write,
  input  logic         req_valid,
  output logic         req_stall,
  input  xrru_status_t status,
  output xrru_cmd_t    cmd
);

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [1:0]           word_idx;
  logic                 accept;

  assign accept = (state == ST_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SEED_INIT;
      step_cnt <= '0;
      word_idx <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step_cnt <= '0;
      end else if (state == ST_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (state == ST_SEED_INIT) begin
        word_idx <= '0;
      end else if (state == ST_STORE) begin
        word_idx <= word_idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    if (seed_write) begin
      state_next = ST_SEED_INIT;
    end else begin
      unique case (state)
        ST_SEED_INIT: state_next = ST_SEED_ADD;
        ST_SEED_ADD:  state_next = ST_MULA_LO;
        ST_MULA_LO:   state_next = ST_MULA_HI;
        ST_MULA_HI:   state_next = ST_MULA_X;
        ST_MULA_X:    state_next = ST_MIX;
        ST_MIX:       state_next = ST_MULB_LO;
        ST_MULB_LO:   state_next = ST_MULB_HI;
        ST_MULB_HI:   state_next = ST_MULB_X;
        ST_MULB_X:    state_next = ST_STORE;
        ST_STORE:     state_next = (word_idx == 2'd3) ? ST_IDLE : ST_SEED_ADD;
        ST_IDLE: begin
          if (req_valid) begin
            state_next = status.need_div ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_next = ST_FIN;
          end
        end
        ST_FIN: begin
          if (status.out_free) begin
            state_next = ST_IDLE;
          end
        end
        default: state_next = ST_SEED_INIT;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.word_idx = word_idx;
    req_stall    = (state != ST_IDLE);
    unique case (state)
      ST_SEED_INIT: cmd.seed_init = 1'b1;
      ST_SEED_ADD:  cmd.seed_add = 1'b1;
      ST_MULA_LO:   cmd.mul_lo = 1'b1;
      ST_MULA_HI:   cmd.mul_cross_hi = 1'b1;
      ST_MULA_X:    cmd.mul_cross_lo = 1'b1;
      ST_MIX:       cmd.mix = 1'b1;
      ST_MULB_LO: begin
        cmd.mul_lo      = 1'b1;
        cmd.mul_const_b = 1'b1;
      end
      ST_MULB_HI: begin
        cmd.mul_cross_hi = 1'b1;
        cmd.mul_const_b  = 1'b1;
      end
      ST_MULB_X: begin
        cmd.mul_cross_lo = 1'b1;
        cmd.mul_const_b  = 1'b1;
      end
      ST_STORE:     cmd.store = 1'b1;
      ST_IDLE:      cmd.accept = accept;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_FIN:       cmd.finish = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// File: rtl/xrru_datapath.sv
// ---------------------------------------------------------------------------
// xrru_datapath
// Generator state, seed expansion multiplier, remainder divider and result
// register.
// ---------------------------------------------------------------------------
module xrru_datapath
  import xrru_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  xrru_cmd_t           cmd,
  output xrru_status_t        status,
  input  logic [63:0]         seed_value,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  range_low,
  input  logic signed [31:0]  range_high,
  input  logic signed [31:0]  item_count,
  input  logic [24:0]         probability_q24,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [31:0]         raw_word,
  output logic [23:0]         fraction_q24,
  output logic signed [31:0]  int_result,
  output logic                chance_hit
);

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned k);
    rotl32 = (v << k) | (v >> (32 - k));
  endfunction

  logic [31:0] gen_words [4];
  logic [63:0] acc;
  logic [63:0] zop;
  logic [63:0] prod;

  logic [1:0]  kind_r;
  logic [31:0] low_r;
  logic [31:0] divisor_r;
  logic [31:0] dividend_r;
  logic [31:0] rem_r;
  logic [31:0] word_r;
  logic [24:0] prob_r;
  logic        need_div_r;

  // generator step
  logic [31:0] draw_out;
  logic [31:0] s0_next, s1_next, s2_next, s3_next;
  logic [31:0] s2_mid, s3_mid;

  always_comb begin
    draw_out = rotl32(gen_words[0] + gen_words[3], 7) + gen_words[0];
    s2_mid   = gen_words[2] ^ gen_words[0];
    s3_mid   = gen_words[3] ^ gen_words[1];
    s1_next  = gen_words[1] ^ s2_mid;
    s0_next  = gen_words[0] ^ s3_mid;
    s2_next  = s2_mid ^ (gen_words[1] << 9);
    s3_next  = rotl32(s3_mid, 11);
  end

  // request decode
  logic        range_empty;
  logic [31:0] span;
  logic        count_pos;
  logic        draw;
  logic        need_div;
  logic [31:0] divisor;

  assign range_empty = (range_high <= range_low);
  assign span        = 32'(range_high) - 32'(range_low) + 32'd1;
  assign count_pos   = !item_count[31] && (item_count != 32'sd0);

  always_comb begin
    unique case (req_type)
      REQ_RAW: begin
        draw     = 1'b1;
        need_div = 1'b0;
        divisor  = span;
      end
      REQ_RANGE: begin
        draw     = !range_empty;
        need_div = !range_empty && (span != 32'd0);
        divisor  = span;
      end
      REQ_INDEX: begin
        draw     = count_pos;
        need_div = count_pos;
        divisor  = 32'(item_count);
      end
      REQ_CHANCE: begin
        draw     = 1'b1;
        need_div = 1'b0;
        divisor  = span;
      end
      default: begin
        draw     = 1'b0;
        need_div = 1'b0;
        divisor  = span;
      end
    endcase
  end

  assign status.need_div = need_div;
  assign status.out_free = !rsp_valid || !rsp_stall;

  // seed expansion
  logic [63:0] mul_const;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;
  logic [63:0] acc_sum;
  logic [63:0] fold31;

  assign mul_const = cmd.mul_const_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_x     = cmd.mul_cross_hi ? zop[63:32] : zop[31:0];
  assign mul_y     = cmd.mul_cross_lo ? mul_const[63:32] : mul_const[31:0];
  assign mul_p     = {32'd0, mul_x} * {32'd0, mul_y};
  assign acc_sum   = acc + GOLDEN_GAMMA;
  assign fold31    = prod ^ (prod >> 31);

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      acc <= (seed_value != 64'd0) ? seed_value : GOLDEN_GAMMA;
    end
    if (cmd.seed_add) begin
      acc <= acc_sum;
      zop <= acc_sum ^ (acc_sum >> 30);
    end
    if (cmd.mix) begin
      zop <= prod ^ (prod >> 27);
    end
    if (cmd.mul_lo) begin
      prod <= mul_p;
    end else if (cmd.mul_cross_hi || cmd.mul_cross_lo) begin
      prod <= prod + {mul_p[31:0], 32'd0};
    end
    if (cmd.store) begin
      gen_words[cmd.word_idx] <= fold31[63:32];
    end else if (cmd.accept && draw) begin
      gen_words[0] <= s0_next;
      gen_words[1] <= s1_next;
      gen_words[2] <= s2_next;
      gen_words[3] <= s3_next;
    end
  end

  // request capture and restoring remainder
  logic [32:0] rem_shift;
  logic [33:0] rem_diff;

  assign rem_shift = {rem_r, dividend_r[31]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_r};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= req_type;
      low_r      <= 32'(range_low);
      divisor_r  <= divisor;
      word_r     <= draw ? draw_out : 32'd0;
      dividend_r <= draw ? draw_out : 32'd0;
      rem_r      <= '0;
      prob_r     <= probability_q24;
      need_div_r <= need_div;
    end else if (cmd.div_step) begin
      rem_r      <= rem_diff[33] ? rem_shift[31:0] : rem_diff[31:0];
      dividend_r <= dividend_r << 1;
    end
  end

  // result
  logic [31:0] addend;
  logic [31:0] base;
  logic [31:0] int_next;
  logic        hit_next;

  always_comb begin
    addend   = need_div_r ? rem_r : word_r;
    base     = (kind_r == REQ_RANGE) ? low_r : 32'd0;
    int_next = ((kind_r == REQ_RANGE) || (kind_r == REQ_INDEX)) ? base + addend : 32'd0;
    hit_next = (kind_r == REQ_CHANCE) && ({1'b0, word_r[31:8]} < prob_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      raw_word     <= word_r;
      fraction_q24 <= word_r[31:8];
      int_result   <= int_next;
      chance_hit   <= hit_next;
    end
  end

endmodule

// File: rtl/xoshiro_random_request_unit.sv
// ---------------------------------------------------------------------------
// xoshiro_random_request_unit
// xoshiro128++ random request unit: raw word, signed range, index and chance
// requests, seeded through SplitMix64.
// ---------------------------------------------------------------------------
// A request is taken when req_valid is high and req_stall is low; one request
// is in work at a time. Raw word, chance and requests that draw no remainder
// (empty range, full 32-bit range, non-positive count) go from acceptance
// straight to the result load; range and index requests that need a
// remainder first pass the one-bit-per-cycle restoring divider (32 steps).
// The result waits in an output register, so the next request is taken
// while it is still stalled. After reset and after each write of the seed
// register the generator state is rebuilt by a SplitMix64 sequencer on one
// shared 32x32 multiplier, with req_stall held high. The seed register sits
// at byte address 0 of the 64-bit APB port.
// ---------------------------------------------------------------------------
module xoshiro_random_request_unit
  import xrru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            req_type,
  input  logic signed [31:0]    range_low,
  input  logic signed [31:0]    range_high,
  input  logic signed [31:0]    item_count,
  input  logic [24:0]           probability_q24,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [31:0]           raw_word,
  output logic [23:0]           fraction_q24,
  output logic signed [31:0]    int_result,
  output logic                  chance_hit
);

  logic [63:0]  seed_value;
  logic         seed_sel;
  logic         seed_write;
  xrru_cmd_t    cmd;
  xrru_status_t status;

  assign pready     = 1'b1;
  assign seed_sel   = (paddr[APB_ADDR_W-1] == REG_SEED);
  assign seed_write = psel && penable && pwrite && pready && seed_sel;
  assign prdata     = seed_sel ? seed_value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= SEED_RESET;
    end else if (seed_write) begin
      seed_value <= pwdata;
    end
  end

  xrru_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .seed_write (seed_write),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .status     (status),
    .cmd        (cmd)
  );

  xrru_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .seed_value      (seed_value),
    .req_type        (req_type),
    .range_low       (range_low),
    .range_high      (range_high),
    .item_count      (item_count),
    .probability_q24 (probability_q24),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .raw_word        (raw_word),
    .fraction_q24    (fraction_q24),
    .int_result      (int_result),
    .chance_hit      (chance_hit)
  );

endmodule

// File: rtl/xrru_checker.sv
// ---------------------------------------------------------------------------
// xrru_checker
// Port-level checks of the random request unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "xoshiro_random_request_unit_macros.svh"

module xrru_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] raw_word,
  input logic [23:0] fraction_q24,
  input logic [31:0] int_result,
  input logic        chance_hit
);

  `XRRU_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(raw_word) && $stable(int_result), "stalled transaction changed")
  `XRRU_ASSERT_SAME(a_fraction, clk, rst, rsp_valid, fraction_q24 == raw_word[31:8], "fraction does not match raw word")
  `XRRU_ASSERT_SAME(a_hit_no_int, clk, rst, rsp_valid && chance_hit, int_result == 32'd0, "chance transaction carries an int result")
  `XRRU_ASSERT_NEXT(a_one_in_work, clk, rst, req_valid && !req_stall, req_stall, "request taken while another is in work")

endmodule

bind xoshiro_random_request_unit xrru_checker u_checker (.*);
